@@ rtl/core/cerp_pkg.sv @@
// Package for the CBOR edge record parser: payload structs, parser state,
// phase codes and the hex digit helper. No dependencies.

package cerp_pkg;

  localparam logic [2:0] PH_MAP  = 3'd0;
  localparam logic [2:0] PH_KEY  = 3'd1;
  localparam logic [2:0] PH_SHDR = 3'd2;
  localparam logic [2:0] PH_SEXT = 3'd3;
  localparam logic [2:0] PH_HASH = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;
  localparam logic [2:0] PH_THDR = 3'd6;
  localparam logic [2:0] PH_ERR  = 3'd7;

  localparam logic [2:0] MAJ_UINT  = 3'd0;
  localparam logic [2:0] MAJ_BSTR  = 3'd2;
  localparam logic [2:0] MAJ_MAP   = 3'd5;

  localparam logic [4:0] MAX_ENTRIES = 5'd23;
  localparam logic [4:0] AI_1BYTE    = 5'd24;
  localparam logic [4:0] AI_2BYTE    = 5'd25;
  localparam logic [4:0] AI_4BYTE    = 5'd26;
  localparam logic [4:0] AI_8BYTE    = 5'd27;

  localparam logic [4:0] KEY_HASH  = 5'd0;
  localparam logic [4:0] KEY_SKIP3 = 5'd1;
  localparam logic [4:0] KEY_UINT  = 5'd2;

  localparam logic [5:0] HASH_LEN_SHORT = 6'd20;
  localparam logic [5:0] HASH_LEN_LONG  = 6'd32;
  localparam logic [3:0] KEY1_SKIP      = 4'd3;

  localparam logic [6:0] ASCII_ZERO = 7'd48;
  localparam logic [6:0] ASCII_AOFS = 7'd87;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       hash_valid;
    logic [7:0] hash_byte;
    logic [4:0] hash_index;
    logic [5:0] hash_length;
    logic [6:0] hex_high;
    logic [6:0] hex_low;
    logic       record_end;
    logic       status;
  } out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] entries_left;
    logic [5:0] string_length;
    logic [5:0] string_count;
    logic [3:0] skip_left;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_MAP,
    entries_left:  5'd0,
    string_length: 6'd0,
    string_count:  6'd0,
    skip_left:     4'd0
  };

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      return ASCII_ZERO + ext;
    end
    return ASCII_AOFS + ext;
  endfunction

endpackage

@@ rtl/core/cerp_in_if.sv @@
// Byte input channel of the CBOR edge record parser: valid/ready plus payload.
// Depends on cerp_pkg.

interface cerp_in_if;
  logic         valid;
  logic         ready;
  cerp_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/cerp_out_if.sv @@
// Result channel of the CBOR edge record parser: valid/ready plus payload.
// Depends on cerp_pkg.

interface cerp_out_if;
  logic          valid;
  logic          ready;
  cerp_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/cerp_step.sv @@
// Next-state and result logic of the parser for one record byte.
// Purely combinational; depends on cerp_pkg.

module cerp_step (
  input  cerp_pkg::state_t state_i,
  input  cerp_pkg::in_t    byte_i,
  output cerp_pkg::state_t state_o,
  output cerp_pkg::out_t   res_o
);

  logic [2:0] major;
  logic [4:0] low;
  logic [5:0] cnt_inc;
  logic [3:0] skip_dec;
  logic       hv;
  logic       bad;
  cerp_pkg::state_t nxt;

  assign major    = byte_i.in_byte[7:5];
  assign low      = byte_i.in_byte[4:0];
  assign cnt_inc  = state_i.string_count + 6'd1;
  assign skip_dec = state_i.skip_left - 4'd1;

  always_comb begin
    nxt = state_i;
    hv  = 1'b0;
    case (state_i.phase)
      cerp_pkg::PH_MAP: begin
        if (major != cerp_pkg::MAJ_MAP || low > cerp_pkg::MAX_ENTRIES) begin
          nxt.phase = cerp_pkg::PH_ERR;
        end else begin
          nxt.entries_left = low;
          nxt.phase        = cerp_pkg::PH_KEY;
        end
      end
      cerp_pkg::PH_KEY: begin
        if (state_i.entries_left != 5'd0) begin
          nxt.entries_left = state_i.entries_left - 5'd1;
          if (major != cerp_pkg::MAJ_UINT) begin
            nxt.phase = cerp_pkg::PH_ERR;
          end else if (low == cerp_pkg::KEY_HASH) begin
            nxt.phase = cerp_pkg::PH_SHDR;
          end else if (low == cerp_pkg::KEY_SKIP3) begin
            nxt.skip_left = cerp_pkg::KEY1_SKIP;
            nxt.phase     = cerp_pkg::PH_SKIP;
          end else if (low == cerp_pkg::KEY_UINT) begin
            nxt.phase = cerp_pkg::PH_THDR;
          end else begin
            nxt.phase = cerp_pkg::PH_ERR;
          end
        end
      end
      cerp_pkg::PH_SHDR: begin
        if (major != cerp_pkg::MAJ_BSTR) begin
          nxt.phase = cerp_pkg::PH_ERR;
        end else if (low == cerp_pkg::AI_1BYTE) begin
          nxt.phase = cerp_pkg::PH_SEXT;
        end else if ({1'b0, low} == cerp_pkg::HASH_LEN_SHORT) begin
          nxt.string_length = {1'b0, low};
          nxt.string_count  = 6'd0;
          nxt.phase         = cerp_pkg::PH_HASH;
        end else begin
          nxt.phase = cerp_pkg::PH_ERR;
        end
      end
      cerp_pkg::PH_SEXT: begin
        if (byte_i.in_byte == {2'b00, cerp_pkg::HASH_LEN_SHORT} ||
            byte_i.in_byte == {2'b00, cerp_pkg::HASH_LEN_LONG}) begin
          nxt.string_length = byte_i.in_byte[5:0];
          nxt.string_count  = 6'd0;
          nxt.phase         = cerp_pkg::PH_HASH;
        end else begin
          nxt.phase = cerp_pkg::PH_ERR;
        end
      end
      cerp_pkg::PH_HASH: begin
        hv               = 1'b1;
        nxt.string_count = cnt_inc;
        if (cnt_inc >= state_i.string_length) begin
          nxt.phase = cerp_pkg::PH_KEY;
        end
      end
      cerp_pkg::PH_SKIP: begin
        nxt.skip_left = skip_dec;
        if (skip_dec == 4'd0) begin
          nxt.phase = cerp_pkg::PH_KEY;
        end
      end
      cerp_pkg::PH_THDR: begin
        case (low)
          cerp_pkg::AI_1BYTE: nxt.skip_left = 4'd1;
          cerp_pkg::AI_2BYTE: nxt.skip_left = 4'd2;
          cerp_pkg::AI_4BYTE: nxt.skip_left = 4'd4;
          cerp_pkg::AI_8BYTE: nxt.skip_left = 4'd8;
          default:            nxt.skip_left = 4'd0;
        endcase
        nxt.phase = (nxt.skip_left == 4'd0) ? cerp_pkg::PH_KEY : cerp_pkg::PH_SKIP;
      end
      default: begin
        nxt.phase = cerp_pkg::PH_ERR;
      end
    endcase
  end

  always_comb begin
    bad = (nxt.phase == cerp_pkg::PH_ERR);
    if (byte_i.last_byte) begin
      if (nxt.phase == cerp_pkg::PH_MAP  || nxt.phase == cerp_pkg::PH_SHDR ||
          nxt.phase == cerp_pkg::PH_SEXT || nxt.phase == cerp_pkg::PH_HASH ||
          nxt.phase == cerp_pkg::PH_THDR) begin
        bad = 1'b1;
      end
      if ((nxt.phase == cerp_pkg::PH_KEY || nxt.phase == cerp_pkg::PH_SKIP) &&
          nxt.entries_left != 5'd0) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.hash_valid  = hv;
    res_o.hash_byte   = hv ? byte_i.in_byte : 8'd0;
    res_o.hash_index  = hv ? state_i.string_count[4:0] : 5'd0;
    res_o.hash_length = nxt.string_length;
    res_o.hex_high    = hv ? cerp_pkg::hex_digit(byte_i.in_byte[7:4]) : cerp_pkg::ASCII_ZERO;
    res_o.hex_low     = hv ? cerp_pkg::hex_digit(byte_i.in_byte[3:0]) : cerp_pkg::ASCII_ZERO;
    res_o.record_end  = byte_i.last_byte;
    res_o.status      = bad;
  end

  // a record's final byte returns the parser to its reset state
  assign state_o = byte_i.last_byte ? cerp_pkg::STATE_RESET : nxt;

endmodule

@@ rtl/core/cbor_edge_record_parser_core.sv @@
// Top level of the CBOR edge record parser: state and result registers.
// Depends on cerp_pkg, cerp_in_if, cerp_out_if and cerp_step.
//
// Usage:
//   in_i  carries one record byte per transaction (in_byte, last_byte);
//         last_byte marks the final byte, the next byte starts a new record.
//   out_o carries exactly one result per input byte, in order: hash byte
//         flag, byte, index and length, its two lowercase hex digits,
//         record_end and a status bit that is final on record_end.
//   A byte accepted at one edge has its result valid after that edge.
//   It takes one byte per cycle while results are taken; the parser state is
//   a single register updated by one level of decode logic per byte.
//   The block takes a new byte while a result is held, as long as that
//   result is taken in the same cycle; when the receiver stalls, the result
//   register holds and in_i.ready drops until it is taken.
//   Reset puts the parser at the start of a record (expecting a map header)
//   and empties the result register.

module cbor_edge_record_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  cerp_in_if.sink           in_i,
  cerp_out_if.source        out_o
);

  cerp_pkg::state_t state_q;
  cerp_pkg::state_t state_d;
  cerp_pkg::out_t   res_d;
  cerp_pkg::out_t   res_q;
  logic             valid_q;
  logic             accept;

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  cerp_step u_step (
    .state_i (state_q),
    .byte_i  (in_i.data),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cerp_pkg::STATE_RESET;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = res_q;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for cbor_edge_record_parser_core: random and directed
// records through valid/ready channels, checked against a cycle-free predictor.
// Depends on cerp_pkg, cerp_in_if, cerp_out_if and the parser RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cerp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    in_t         txn;
    int unsigned gap;
    bit          drain;
  } byte_txn_t;

  logic clk_i;
  logic rst_ni;

  cerp_in_if  in_ch ();
  cerp_out_if out_ch ();

  cbor_edge_record_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  byte_txn_t   record_bytes[$];
  out_t        results_due[$];
  state_t      parse_st;
  logic        in_fire;
  logic        out_fire;
  logic        rcv_hold;
  bit          send_calm;
  bit          rcv_calm;
  int unsigned send_gap;
  int unsigned rcv_wait;
  int unsigned n_accepted;
  int unsigned mismatches;
  int unsigned cycles;

  function automatic logic [6:0] nib_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? ASCII_ZERO + 7'(nib) : ASCII_AOFS + 7'(nib);
  endfunction

  // Advances the parser state by one byte and returns the result it causes.
  function automatic out_t decode_byte(input in_t txn);
    logic [7:0] b;
    logic [2:0] major;
    logic [4:0] low;
    logic       hv;
    logic [4:0] idx;
    logic       bad;
    out_t       r;
    b = txn.in_byte;
    major = b[7:5];
    low = b[4:0];
    hv = 1'b0;
    idx = '0;
    case (parse_st.phase)
      PH_MAP: begin
        if (major != MAJ_MAP || low > MAX_ENTRIES) begin
          parse_st.phase = PH_ERR;
        end else begin
          parse_st.entries_left = low;
          parse_st.phase = PH_KEY;
        end
      end
      PH_KEY: begin
        if (parse_st.entries_left != '0) begin
          parse_st.entries_left = parse_st.entries_left - 5'd1;
          if (major != MAJ_UINT) begin
            parse_st.phase = PH_ERR;
          end else if (low == KEY_HASH) begin
            parse_st.phase = PH_SHDR;
          end else if (low == KEY_SKIP3) begin
            parse_st.skip_left = KEY1_SKIP;
            parse_st.phase = PH_SKIP;
          end else if (low == KEY_UINT) begin
            parse_st.phase = PH_THDR;
          end else begin
            parse_st.phase = PH_ERR;
          end
        end
      end
      PH_SHDR: begin
        if (major != MAJ_BSTR) begin
          parse_st.phase = PH_ERR;
        end else if (low == AI_1BYTE) begin
          parse_st.phase = PH_SEXT;
        end else if (6'(low) == HASH_LEN_SHORT || 6'(low) == HASH_LEN_LONG) begin
          parse_st.string_length = 6'(low);
          parse_st.string_count = '0;
          parse_st.phase = PH_HASH;
        end else begin
          parse_st.phase = PH_ERR;
        end
      end
      PH_SEXT: begin
        if (b == 8'(HASH_LEN_SHORT) || b == 8'(HASH_LEN_LONG)) begin
          parse_st.string_length = 6'(b);
          parse_st.string_count = '0;
          parse_st.phase = PH_HASH;
        end else begin
          parse_st.phase = PH_ERR;
        end
      end
      PH_HASH: begin
        hv = 1'b1;
        idx = parse_st.string_count[4:0];
        parse_st.string_count = parse_st.string_count + 6'd1;
        if (parse_st.string_count >= parse_st.string_length) parse_st.phase = PH_KEY;
      end
      PH_SKIP: begin
        parse_st.skip_left = parse_st.skip_left - 4'd1;
        if (parse_st.skip_left == '0) parse_st.phase = PH_KEY;
      end
      PH_THDR: begin
        case (low)
          AI_1BYTE: parse_st.skip_left = 4'd1;
          AI_2BYTE: parse_st.skip_left = 4'd2;
          AI_4BYTE: parse_st.skip_left = 4'd4;
          AI_8BYTE: parse_st.skip_left = 4'd8;
          default:  parse_st.skip_left = 4'd0;
        endcase
        parse_st.phase = (parse_st.skip_left == '0) ? PH_KEY : PH_SKIP;
      end
      default: parse_st.phase = PH_ERR;
    endcase

    bad = (parse_st.phase == PH_ERR);
    if (txn.last_byte) begin
      if (parse_st.phase == PH_MAP || parse_st.phase == PH_SHDR ||
          parse_st.phase == PH_SEXT || parse_st.phase == PH_HASH ||
          parse_st.phase == PH_THDR) bad = 1'b1;
      if ((parse_st.phase == PH_KEY || parse_st.phase == PH_SKIP) &&
          parse_st.entries_left != '0) bad = 1'b1;
    end

    r.hash_valid  = hv;
    r.hash_byte   = hv ? b : 8'd0;
    r.hash_index  = idx;
    r.hash_length = parse_st.string_length;
    r.hex_high    = hv ? nib_ascii(b[7:4]) : ASCII_ZERO;
    r.hex_low     = hv ? nib_ascii(b[3:0]) : ASCII_ZERO;
    r.record_end  = txn.last_byte;
    r.status      = bad;
    if (txn.last_byte) parse_st = STATE_RESET;
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic add_byte(input logic [7:0] b, input bit last, input bit drain);
    byte_txn_t t;
    t.txn.in_byte = b;
    t.txn.last_byte = last;
    t.gap = send_calm ? 0 : $urandom_range(0, 16);
    t.drain = drain;
    record_bytes.push_back(t);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("cbor_edge_record_parser_core: mismatch");
      $finish;
    end
  end

  // Scoreboard: retire results first, then predict the byte taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    out_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
      parse_st = STATE_RESET;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      out_fire <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report("result transaction with none expected");
        end else begin
          want = results_due.pop_front();
          check_field("hash_valid", 8'(out_ch.data.hash_valid), 8'(want.hash_valid));
          check_field("hash_byte", out_ch.data.hash_byte, want.hash_byte);
          check_field("hash_index", 8'(out_ch.data.hash_index), 8'(want.hash_index));
          check_field("hash_length", 8'(out_ch.data.hash_length), 8'(want.hash_length));
          check_field("hex_high", 8'(out_ch.data.hex_high), 8'(want.hex_high));
          check_field("hex_low", 8'(out_ch.data.hex_low), 8'(want.hex_low));
          check_field("record_end", 8'(out_ch.data.record_end), 8'(want.record_end));
          check_field("status", 8'(out_ch.data.status), 8'(want.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(decode_byte(in_ch.data));
        n_accepted++;
      end
    end
  end

  always @(negedge clk_i) begin : drive_bytes
    logic      offer;
    byte_txn_t t;
    offer = in_ch.valid && !in_fire;
    if (rst_ni && !offer) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (record_bytes.size() != 0 &&
                   !(record_bytes[0].drain && results_due.size() != 0)) begin
        t = record_bytes.pop_front();
        in_ch.data <= t.txn;
        send_gap = t.gap;
        offer = 1'b1;
      end
    end
    in_ch.valid <= offer;
  end

  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 49) == 0) rcv_calm = !rcv_calm;
        rcv_wait = rcv_calm ? 0 : $urandom_range(0, 16);
      end else if (rcv_wait != 0) begin
        rcv_wait--;
      end
      out_ch.ready <= !rcv_hold && rcv_wait == 0;
    end
  end

  // Long receiver stall while the sender keeps offering bytes.
  initial begin
    rcv_hold = 1'b0;
    wait (n_accepted >= 300);
    @(posedge clk_i);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rcv_hold <= 1'b0;
  end

  initial begin : stimulus
    logic [7:0]  rec[$];
    logic [7:0]  hdr;
    int unsigned n_ent;
    int unsigned key;
    int unsigned len;
    int unsigned nx;
    int unsigned kind;
    int unsigned n_random;
    bit          drain;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    send_calm = 1'b0;
    rcv_calm = 1'b0;
    send_gap = 0;
    rcv_wait = 0;
    n_accepted = 0;
    mismatches = 0;
    cycles = 0;
    n_random = 0;

    // empty map, bad map major, oversized map
    add_byte({MAJ_MAP, 5'd0}, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte({MAJ_MAP, AI_1BYTE}, 1'b1, 1'b0);
    // skip entry cut short after the final entry: not an error
    add_byte({MAJ_MAP, 5'd1}, 1'b0, 1'b0);
    add_byte({MAJ_UINT, KEY_SKIP3}, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    // unknown key value, key with wrong major
    add_byte({MAJ_MAP, 5'd1}, 1'b0, 1'b0);
    add_byte({MAJ_UINT, 5'd3}, 1'b1, 1'b0);
    add_byte({MAJ_MAP, MAX_ENTRIES}, 1'b0, 1'b0);
    add_byte({3'd1, KEY_HASH}, 1'b1, 1'b0);
    // bad string length, then extended header cut short
    add_byte({MAJ_MAP, 5'd1}, 1'b0, 1'b0);
    add_byte({MAJ_UINT, KEY_HASH}, 1'b0, 1'b0);
    add_byte({MAJ_BSTR, 5'd1}, 1'b1, 1'b0);
    add_byte({MAJ_MAP, 5'd1}, 1'b0, 1'b0);
    add_byte({MAJ_UINT, KEY_HASH}, 1'b0, 1'b0);
    add_byte({MAJ_BSTR, AI_1BYTE}, 1'b1, 1'b0);
    // uint entry with eight extra bytes cut short, then trailing bytes
    add_byte({MAJ_MAP, 5'd1}, 1'b0, 1'b0);
    add_byte({MAJ_UINT, KEY_UINT}, 1'b0, 1'b0);
    add_byte({3'd7, AI_8BYTE}, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte({MAJ_MAP, 5'd0}, 1'b0, 1'b0);
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b1, 1'b0);

    while (n_random < RANDOM_ITEMS) begin
      rec = {};
      n_ent = ($urandom_range(0, 29) == 0) ? 23 : $urandom_range(0, 4);
      rec.push_back({MAJ_MAP, 5'(n_ent)});
      repeat (n_ent) begin
        key = $urandom_range(0, 2);
        rec.push_back({MAJ_UINT, 5'(key)});
        if (5'(key) == KEY_HASH) begin
          len = $urandom_range(0, 1) ? 20 : 32;
          if (len == 32 || $urandom_range(0, 1)) begin
            rec.push_back({MAJ_BSTR, AI_1BYTE});
            rec.push_back(8'(len));
          end else begin
            rec.push_back({MAJ_BSTR, 5'(len)});
          end
          repeat (len) rec.push_back(8'($urandom));
        end else if (5'(key) == KEY_SKIP3) begin
          repeat (KEY1_SKIP) rec.push_back(8'($urandom));
        end else begin
          hdr = 8'($urandom);
          case (hdr[4:0])
            AI_1BYTE: nx = 1;
            AI_2BYTE: nx = 2;
            AI_4BYTE: nx = 4;
            AI_8BYTE: nx = 8;
            default:  nx = 0;
          endcase
          rec.push_back(hdr);
          repeat (nx) rec.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
      end

      kind = $urandom_range(0, 99);
      if (kind >= 70 && kind < 80) begin
        rec = rec[0:$urandom_range(0, rec.size() - 1)];
      end else if (kind >= 80 && kind < 90) begin
        rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom);
      end else if (kind >= 90) begin
        rec = {};
        repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom));
      end

      send_calm = ($urandom_range(0, 3) == 0);
      drain = (n_random == 0) || ($urandom_range(0, 14) == 0);
      foreach (rec[i]) add_byte(rec[i], i == rec.size() - 1, drain && i == 0);
      n_random += rec.size();
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (record_bytes.size() != 0 || in_ch.valid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("cbor_edge_record_parser_core: match");
    end else begin
      $display("cbor_edge_record_parser_core: mismatch");
    end
    $finish;
  end

endmodule
